// ===== design/scs_pkg.sv =====
// Shared types and character constants for the script comment stripper.
`default_nettype none

package scs_pkg;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } scan_mode_t;

    // One queued work entry: an optional leading slash, then a kept byte or the end marker.
    typedef struct packed {
        logic       slash_first;
        logic       is_end;
        logic [7:0] ch;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/scs_front.sv =====
// Front end: accepts transactions, tracks scan state, classifies into queue entries.
`default_nettype none

module scs_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic           command,
    input  wire logic [7:0]     data_byte,
    input  wire logic           q_full,
    output scs_pkg::entry_t     q_entry,
    output logic                q_push
);

    scs_pkg::scan_mode_t mode_reg, mode_next;
    logic [7:0]          quote_reg, quote_next;
    logic [7:0]          prev_reg, prev_next;
    logic                slash_reg, slash_next;
    logic                star_reg, star_next;
    logic                accept;
    logic                emit;

    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= scs_pkg::MODE_NORMAL;
            quote_reg <= 8'h00;
            prev_reg  <= 8'h00;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            prev_reg  <= prev_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        prev_next  = prev_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        emit       = 1'b0;
        q_entry    = '0;
        q_entry.ch = data_byte;

        if (accept)
        begin
            if (command == scs_pkg::CMD_END)
            begin
                q_entry.slash_first = slash_reg;
                q_entry.is_end      = 1'b1;
                q_entry.ch          = 8'h00;
                emit                = 1'b1;
                mode_next           = scs_pkg::MODE_NORMAL;
                quote_next          = 8'h00;
                prev_next           = 8'h00;
                slash_next          = 1'b0;
                star_next           = 1'b0;
            end
            else
            begin
                prev_next = data_byte;
                unique case (mode_reg)
                    scs_pkg::MODE_LINE:
                    begin
                        if (data_byte == scs_pkg::CH_NEWLINE)
                        begin
                            mode_next = scs_pkg::MODE_NORMAL;
                            emit      = 1'b1;
                        end
                    end
                    scs_pkg::MODE_BLOCK:
                    begin
                        if (star_reg && data_byte == scs_pkg::CH_SLASH)
                        begin
                            mode_next = scs_pkg::MODE_NORMAL;
                            star_next = 1'b0;
                        end
                        else
                        begin
                            star_next = (data_byte == scs_pkg::CH_STAR);
                        end
                    end
                    scs_pkg::MODE_STRING:
                    begin
                        if (data_byte == quote_reg && prev_reg != scs_pkg::CH_BACKSLASH)
                        begin
                            mode_next = scs_pkg::MODE_NORMAL;
                        end
                        emit = 1'b1;
                    end
                    default:
                    begin
                        if (slash_reg && data_byte == scs_pkg::CH_SLASH)
                        begin
                            slash_next = 1'b0;
                            mode_next  = scs_pkg::MODE_LINE;
                        end
                        else if (slash_reg && data_byte == scs_pkg::CH_STAR)
                        begin
                            slash_next = 1'b0;
                            mode_next  = scs_pkg::MODE_BLOCK;
                            star_next  = 1'b0;
                        end
                        else
                        begin
                            // held slash with any other successor goes out first
                            q_entry.slash_first = slash_reg;
                            slash_next          = 1'b0;
                            if (data_byte == scs_pkg::CH_DQUOTE ||
                                data_byte == scs_pkg::CH_SQUOTE)
                            begin
                                mode_next  = scs_pkg::MODE_STRING;
                                quote_next = data_byte;
                                emit       = 1'b1;
                            end
                            else if (data_byte == scs_pkg::CH_SLASH)
                            begin
                                slash_next = 1'b1;
                                if (slash_reg)
                                begin
                                    emit = 1'b1;
                                end
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
        q_push = emit;
    end

endmodule

`default_nettype wire

// ===== design/scs_fifo.sv =====
// Short entry queue between the front end and the output sequencer.
`default_nettype none

module scs_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire scs_pkg::entry_t wr_entry,
    input  wire logic            rd_en,
    output scs_pkg::entry_t      rd_entry,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    scs_pkg::entry_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

// ===== design/scs_back.sv =====
// Back end: expands queue entries into result transactions through an output register.
`default_nettype none

module scs_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scs_pkg::entry_t q_entry,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic                 byte_present,
    output logic [7:0]           out_char,
    output logic                 run_end,
    output logic                 text_end
);

    logic       valid_reg, valid_next;
    logic       phase_reg, phase_next;
    logic       present_reg, present_next;
    logic [7:0] char_reg, char_next;
    logic       run_end_reg, run_end_next;
    logic       text_end_reg, text_end_next;
    logic       load;

    assign load         = !valid_reg || pop;
    assign empty        = !valid_reg;
    assign byte_present = present_reg;
    assign out_char     = char_reg;
    assign run_end      = run_end_reg;
    assign text_end     = text_end_reg;

    always_comb
    begin
        valid_next    = valid_reg;
        phase_next    = phase_reg;
        present_next  = present_reg;
        char_next     = char_reg;
        run_end_next  = run_end_reg;
        text_end_next = text_end_reg;
        q_pop         = 1'b0;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                if (q_entry.slash_first && !phase_reg)
                begin
                    present_next  = 1'b1;
                    char_next     = scs_pkg::CH_SLASH;
                    run_end_next  = 1'b0;
                    text_end_next = 1'b0;
                    phase_next    = 1'b1;
                end
                else
                begin
                    present_next  = !q_entry.is_end;
                    char_next     = q_entry.is_end ? 8'h00 : q_entry.ch;
                    run_end_next  = 1'b1;
                    text_end_next = q_entry.is_end;
                    phase_next    = 1'b0;
                    q_pop         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        present_reg  <= present_next;
        char_reg     <= char_next;
        run_end_reg  <= run_end_next;
        text_end_reg <= text_end_next;
    end

endmodule

`default_nettype wire

// ===== design/script_comment_stripper_core.sv =====
// Top level of the script comment stripper: front end, entry queue, output sequencer.
//
//  channel   direction  handshake           payload
//  input     in         push / full         command, data_byte
//  result    out        pop / empty         byte_present, out_char, run_end, text_end
//
// One input transaction is accepted per cycle while the entry queue has room.
// Each result transaction is held in the output register until popped; an item with two
// results fills it twice in turn. Entries pass the queue, then the output register.
// rst_n clears scan state, queue pointers and the output valid flag asynchronously.
// A stalled result side fills the queue of QUEUE_DEPTH entries, then full rises.
`default_nettype none

module script_comment_stripper_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       command,
    input  wire logic [7:0] data_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic            byte_present,
    output logic [7:0]      out_char,
    output logic            run_end,
    output logic            text_end
);

    scs_pkg::entry_t wr_entry;
    scs_pkg::entry_t rd_entry;
    logic            wr_en;
    logic            rd_en;
    logic            q_empty;

    scs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (command),
        .data_byte (data_byte),
        .q_full    (full),
        .q_entry   (wr_entry),
        .q_push    (wr_en)
    );

    scs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_entry (rd_entry),
        .full     (full),
        .empty    (q_empty)
    );

    scs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_entry      (rd_entry),
        .q_empty      (q_empty),
        .q_pop        (rd_en),
        .pop          (pop),
        .empty        (empty),
        .byte_present (byte_present),
        .out_char     (out_char),
        .run_end      (run_end),
        .text_end     (text_end)
    );

`ifndef SYNTHESIS
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && q_empty))
        else $error("queue full and empty together");

    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_end) |-> (!byte_present && out_char == 8'h00 && run_end))
        else $error("malformed end marker");

    a_lead_slash: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !run_end) |-> (byte_present && !text_end &&
                                  out_char == scs_pkg::CH_SLASH))
        else $error("non-final result is not a held slash");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !run_end) |=> !empty)
        else $error("second result of a transaction missing");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_script_comment_stripper_core.sv =====
// Testbench for script_comment_stripper_core: directed and random script text.
module tb_script_comment_stripper_core;

    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS   = 40;
    localparam int PAUSE_EVERY  = 250;

    typedef struct packed {
        logic       byte_present;
        logic [7:0] out_char;
        logic       run_end;
        logic       text_end;
    } strip_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       command   = scs_pkg::CMD_TEXT;
    logic [7:0] data_byte = 8'h00;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic       byte_present;
    logic [7:0] out_char;
    logic       run_end;
    logic       text_end;

    // predictor state
    scs_pkg::scan_mode_t mode_q;
    logic [7:0] quote_q;
    logic [7:0] prev_q;
    logic       slash_q;
    logic       star_q;

    strip_result_t stripped_q[$];
    strip_result_t step_buf[$];
    strip_result_t want;

    int items_sent      = 0;
    int ends_sent       = 0;
    int results_checked = 0;
    int strings_opened  = 0;
    int line_comments   = 0;
    int block_comments  = 0;
    int slashes_flushed = 0;
    int err_count       = 0;
    int burst_left      = 0;
    int stall_style     = 0;
    int stall_span      = 0;
    int pop_phase       = 0;
    int idle_cycles     = 0;

    script_comment_stripper_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .byte_present (byte_present),
        .out_char     (out_char),
        .run_end      (run_end),
        .text_end     (text_end)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("result %0d %s: got %02h, expected %02h",
                                      results_checked, name, got, exp));
    endtask

    task automatic emit(input logic present, input logic [7:0] ch, input logic tend);
        strip_result_t r;
        r.byte_present = present;
        r.out_char     = ch;
        r.run_end      = 1'b0;
        r.text_end     = tend;
        step_buf.push_back(r);
    endtask

    task automatic clear_scan();
        mode_q  = scs_pkg::MODE_NORMAL;
        quote_q = 8'h00;
        prev_q  = 8'h00;
        slash_q = 1'b0;
        star_q  = 1'b0;
    endtask

    task automatic scan_normal(input logic [7:0] b);
        if (b == scs_pkg::CH_DQUOTE || b == scs_pkg::CH_SQUOTE)
        begin
            mode_q  = scs_pkg::MODE_STRING;
            quote_q = b;
            strings_opened++;
            emit(1'b1, b, 1'b0);
        end
        else if (b == scs_pkg::CH_SLASH)
            slash_q = 1'b1;
        else
            emit(1'b1, b, 1'b0);
    endtask

    task automatic strip_byte(input logic cmd, input logic [7:0] b);
        strip_result_t r;
        step_buf.delete();
        if (cmd == scs_pkg::CMD_END)
        begin
            if (slash_q)
            begin
                emit(1'b1, scs_pkg::CH_SLASH, 1'b0);
                slashes_flushed++;
            end
            emit(1'b0, 8'h00, 1'b1);
            clear_scan();
        end
        else
        begin
            case (mode_q)
                scs_pkg::MODE_LINE:
                    if (b == scs_pkg::CH_NEWLINE)
                    begin
                        mode_q = scs_pkg::MODE_NORMAL;
                        emit(1'b1, b, 1'b0);
                    end
                scs_pkg::MODE_BLOCK:
                    if (star_q && b == scs_pkg::CH_SLASH)
                    begin
                        mode_q = scs_pkg::MODE_NORMAL;
                        star_q = 1'b0;
                    end
                    else
                        star_q = (b == scs_pkg::CH_STAR);
                scs_pkg::MODE_STRING:
                begin
                    if (b == quote_q && prev_q != scs_pkg::CH_BACKSLASH)
                        mode_q = scs_pkg::MODE_NORMAL;
                    emit(1'b1, b, 1'b0);
                end
                default:
                    if (slash_q)
                    begin
                        slash_q = 1'b0;
                        if (b == scs_pkg::CH_SLASH)
                        begin
                            mode_q = scs_pkg::MODE_LINE;
                            line_comments++;
                        end
                        else if (b == scs_pkg::CH_STAR)
                        begin
                            mode_q = scs_pkg::MODE_BLOCK;
                            star_q = 1'b0;
                            block_comments++;
                        end
                        else
                        begin
                            emit(1'b1, scs_pkg::CH_SLASH, 1'b0);
                            scan_normal(b);
                        end
                    end
                    else
                        scan_normal(b);
            endcase
            prev_q = b;
        end
        if (step_buf.size() > 0)
        begin
            r = step_buf.pop_back();
            r.run_end = 1'b1;
            step_buf.push_back(r);
        end
        foreach (step_buf[i])
            stripped_q.push_back(step_buf[i]);
    endtask

    task automatic hold_off(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // inside a burst push stays high on return so the next item can follow back to back
    task automatic send_item(input logic cmd, input logic [7:0] b);
        push      <= 1'b1;
        command   <= cmd;
        data_byte <= b;
        do @(posedge clk); while (full);
        strip_byte(cmd, b);
        items_sent++;
        if (cmd == scs_pkg::CMD_END)
            ends_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            hold_off($urandom_range(1, 8));
        end
    endtask

    task automatic drain_pause();
        push <= 1'b0;
        do @(posedge clk); while (stripped_q.size() != 0);
    endtask

    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 11))
            0:       return scs_pkg::CH_STAR;
            1:       return scs_pkg::CH_SLASH;
            2:       return scs_pkg::CH_BACKSLASH;
            3:       return scs_pkg::CH_DQUOTE;
            4:       return scs_pkg::CH_SQUOTE;
            5:       return scs_pkg::CH_NEWLINE;
            6:       return 8'($urandom_range(0, 255));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic send_token();
        int         kind;
        int         len;
        logic [7:0] q;
        logic [7:0] b;
        logic [7:0] last;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(0, 8);
        last = 8'h00;
        if (kind < 20)
        begin
            repeat (len + 1) send_item(scs_pkg::CMD_TEXT, 8'h61 + 8'($urandom_range(0, 25)));
            send_item(scs_pkg::CMD_TEXT,
                      ($urandom_range(0, 3) == 0) ? scs_pkg::CH_NEWLINE : 8'h20);
        end
        else if (kind < 40)
        begin
            q = $urandom_range(0, 1) ? scs_pkg::CH_DQUOTE : scs_pkg::CH_SQUOTE;
            send_item(scs_pkg::CMD_TEXT, q);
            repeat (len)
            begin
                b = content_byte();
                if (b == q)
                    b = scs_pkg::CH_BACKSLASH;
                send_item(scs_pkg::CMD_TEXT, b);
                if (b == scs_pkg::CH_BACKSLASH)
                    send_item(scs_pkg::CMD_TEXT, content_byte());
            end
            send_item(scs_pkg::CMD_TEXT, q);
        end
        else if (kind < 55)
        begin
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                send_item(scs_pkg::CMD_TEXT, (b == scs_pkg::CH_NEWLINE) ? 8'h20 : b);
            end
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_NEWLINE);
        end
        else if (kind < 70)
        begin
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_STAR);
            repeat (len)
            begin
                b = content_byte();
                if (b == scs_pkg::CH_SLASH && last == scs_pkg::CH_STAR)
                    b = scs_pkg::CH_NEWLINE;
                send_item(scs_pkg::CMD_TEXT, b);
                last = b;
            end
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_STAR);
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        end
        else if (kind < 80)
        begin
            send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
            send_item(scs_pkg::CMD_TEXT, content_byte());
        end
        else if (kind < 90)
            repeat (len / 2 + 1) send_item(scs_pkg::CMD_TEXT, 8'($urandom_range(0, 255)));
        else if (kind < 95)
            send_item(scs_pkg::CMD_END, 8'($urandom_range(0, 255)));
        else
        begin
            // unterminated string or comment cut off by end of text
            case ($urandom_range(0, 2))
                0: send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_DQUOTE);
                1:
                begin
                    send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
                    send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_STAR);
                end
                default:
                begin
                    send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
                    send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
                end
            endcase
            repeat (len / 2) send_item(scs_pkg::CMD_TEXT, content_byte());
            send_item(scs_pkg::CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_plain_bytes();
        send_item(scs_pkg::CMD_TEXT, 8'h00);
        send_item(scs_pkg::CMD_TEXT, 8'hFF);
        send_item(scs_pkg::CMD_END, 8'hFF);
    endtask

    task automatic test_strings();
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_DQUOTE);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_BACKSLASH);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_DQUOTE);     // escaped, string stays open
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_DQUOTE);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SQUOTE);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_STAR);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SQUOTE);
    endtask

    task automatic test_comments();
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        send_item(scs_pkg::CMD_TEXT, 8'h78);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_NEWLINE);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_STAR);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);      // opening star must not close
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_STAR);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        send_item(scs_pkg::CMD_TEXT, 8'h71);         // held slash released before successor
    endtask

    task automatic test_end_of_text();
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_SLASH);
        send_item(scs_pkg::CMD_END, 8'hA5);          // flushes the held slash
        send_item(scs_pkg::CMD_TEXT, scs_pkg::CH_DQUOTE);
        send_item(scs_pkg::CMD_END, 8'h00);          // open string abandoned
    endtask

    task automatic test_random_stream();
        int stop_at;
        int next_pause;
        stop_at    = items_sent + RANDOM_ITEMS;
        next_pause = items_sent + PAUSE_EVERY;
        while (items_sent < stop_at)
        begin
            send_token();
            if (items_sent >= next_pause)
            begin
                drain_pause();
                next_pause += PAUSE_EVERY;
            end
        end
    endtask

    // result side stall patterns
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_span  = $urandom_range(16, 160);
        end
        stall_span--;
        pop_phase++;
        case (stall_style)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 4) == 0);
            default: pop <= ((pop_phase % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            results_checked++;
            if (stripped_q.size() == 0)
                report_mismatch($sformatf(
                    "unexpected result: present=%0b char=%02h run_end=%0b text_end=%0b",
                    byte_present, out_char, run_end, text_end));
            else
            begin
                want = stripped_q.pop_front();
                check_field("byte_present", 8'(byte_present), 8'(want.byte_present));
                check_field("out_char", out_char, want.out_char);
                check_field("run_end", 8'(run_end), 8'(want.run_end));
                check_field("text_end", 8'(text_end), 8'(want.text_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles = 0;
        else if (++idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, stripped_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_scan();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_plain_bytes();
        test_strings();
        test_comments();
        test_end_of_text();
        drain_pause();
        test_random_stream();
        push <= 1'b0;
        while (stripped_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (stripped_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", stripped_q.size()));
        $display("Run covered %0d input transactions (%0d end of text)", items_sent, ends_sent);
        $display("and %0d result transactions; strings %0d, line %0d, block %0d, flushed %0d.",
                 results_checked, strings_opened, line_comments, block_comments,
                 slashes_flushed);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== script_comment_stripper_core.f =====
design/scs_pkg.sv
design/scs_front.sv
design/scs_fifo.sv
design/scs_back.sv
design/script_comment_stripper_core.sv
bench/tb_script_comment_stripper_core.sv
